### hdl/dersig_pkg.sv
// Shared constants, types and order ROMs for the DER ECDSA signature checker.
// No dependencies; used by dersig_cmp, dersig_parse and the top level.
package dersig_pkg;

   localparam int MAX_SIG_BYTES = 72;
   localparam int MIN_SIG_BYTES = 8;
   localparam int MAX_PART_LEN  = 33;
   localparam int CNT_W         = $clog2(MAX_SIG_BYTES + 2);
   localparam int LEN_W         = 6;
   localparam int IDX_W         = $clog2(MAX_PART_LEN);

   localparam logic [7:0] TAG_SEQ = 8'h30;
   localparam logic [7:0] TAG_INT = 8'h02;

   typedef enum logic [1:0] {
      CMP_EQ = 2'd0,
      CMP_LT = 2'd1,
      CMP_GT = 2'd2
   } cmp_type;

   localparam logic [1:0] STATUS_INVALID   = 2'd0;
   localparam logic [1:0] STATUS_CANONICAL = 2'd1;
   localparam logic [1:0] STATUS_LOW_S     = 2'd2;

   typedef struct packed {
      logic       en;
      logic       last;
      logic [7:0] sig_byte;
   } step_type;

   // secp256k1 order n and (n-1)/2, right-aligned in 33 bytes
   localparam logic [7:0] ORDER_ROM [MAX_PART_LEN] = '{
      8'h00,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
      8'hBA, 8'hAE, 8'hDC, 8'hE6, 8'hAF, 8'h48, 8'hA0, 8'h3B,
      8'hBF, 8'hD2, 8'h5E, 8'h8C, 8'hD0, 8'h36, 8'h41, 8'h41
   };

   localparam logic [7:0] HALF_ROM [MAX_PART_LEN] = '{
      8'h00,
      8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'h5D, 8'h57, 8'h6E, 8'h73, 8'h57, 8'hA4, 8'h50, 8'h1D,
      8'hDF, 8'hE9, 8'h2F, 8'h46, 8'h68, 8'h1B, 8'h20, 8'hA0
   };

   function automatic logic [7:0] rom_byte(input logic [IDX_W-1:0] idx, input logic half);
      logic [7:0] val;
      val = 8'h00;
      if (idx < IDX_W'(MAX_PART_LEN)) begin
         val = half ? HALF_ROM[idx] : ORDER_ROM[idx];
      end
      return val;
   endfunction

endpackage

### hdl/der_ecdsa_sig_canonical_check_core.sv
// Top level of the DER ECDSA low-S canonicality checker (secp256k1).
// Depends on dersig_pkg and dersig_parse.
//
// Usage:
//   req_* : one signature byte per word, first byte first; req_tlast marks
//           the final byte. tdata[7:0] = sig_byte.
//   rsp_* : one word per signature, issued only for the final byte.
//           tdata[1:0] = status (0 invalid, 1 canonical/high S,
//           2 fully canonical/low S), tdata[7:2] zero.
// Path: a final byte passes the input word register and then the result
//   register before its status shows on rsp_tvalid.
// Throughput: one byte per cycle while no final byte is held by a result stall;
//   the parse and all three byte-serial order compares update combinationally between the two registers.
// Stall: while a result waits on rsp_tready, non-final bytes keep flowing;
//   only a following final byte holds in the input register, and req_tready
//   drops once that register cannot drain.
// Reset: synchronous, active high; clears the valid bits of both registers and all parse
//   state, so the next byte is taken as the first byte of a signature.
module der_ecdsa_sig_canonical_check_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] sig_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] status, [7:2] zero
);
   import dersig_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic       out_free;
   logic       adv;
   logic [1:0] status;
   step_type   step;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || adv;

   assign step.en       = adv;
   assign step.last     = in_last_ff;
   assign step.sig_byte = in_byte_ff;

   dersig_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (out_free) rsp_valid_ff <= adv && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (adv && in_last_ff) begin
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff};

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(adv && in_last_ff))
      else $error("result raised without a final word");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("held input word lost");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STATUS_INVALID ||
                        rsp_status_ff == STATUS_CANONICAL ||
                        rsp_status_ff == STATUS_LOW_S))
      else $error("undefined status code");

endmodule

### hdl/dersig_cmp.sv
// One byte step of a right-aligned magnitude compare against n or (n-1)/2.
// Depends on dersig_pkg (ROMs, compare codes).
module dersig_cmp (
   input  logic                        use_half,
   input  dersig_pkg::cmp_type         st,
   input  logic [dersig_pkg::LEN_W-1:0] part_len,
   input  logic [dersig_pkg::LEN_W-1:0] part_pos,
   input  logic [7:0]                  sig_byte,
   output dersig_pkg::cmp_type         st_next
);
   import dersig_pkg::*;

   logic [IDX_W-1:0] idx;
   logic [7:0]       rom_val;
   cmp_type          st_base;

   assign idx     = IDX_W'(MAX_PART_LEN) - IDX_W'(part_len) + IDX_W'(part_pos);
   assign rom_val = rom_byte(idx, use_half);

   always_comb begin
      st_base = st;
      // shorter values skip leading ROM bytes, which are nonzero
      if (part_pos == '0) begin
         st_base = (part_len <= LEN_W'(MAX_PART_LEN - 2)) ? CMP_LT : CMP_EQ;
      end
      st_next = st_base;
      if (st_base == CMP_EQ && idx < IDX_W'(MAX_PART_LEN)) begin
         if (sig_byte < rom_val) begin
            st_next = CMP_LT;
         end else if (sig_byte > rom_val) begin
            st_next = CMP_GT;
         end
      end
   end

endmodule

### hdl/dersig_parse.sv
// DER parse state, length/sign rules and order compares; one word per step.
// Depends on dersig_pkg and dersig_cmp.
module dersig_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  dersig_pkg::step_type step,
   output logic [1:0]           status
);
   import dersig_pkg::*;

   typedef enum logic [2:0] {
      PH_SEQ_TAG = 3'd0,
      PH_SEQ_LEN = 3'd1,
      PH_R_TAG   = 3'd2,
      PH_R_LEN   = 3'd3,
      PH_R_BODY  = 3'd4,
      PH_S_TAG   = 3'd5,
      PH_S_LEN   = 3'd6,
      PH_S_BODY  = 3'd7
   } phase_type;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       decl_ff, decl_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic             lz_ff, lz_in;
   logic             inv_ff, inv_in;
   cmp_type          r_ff, r_in, s_ff, s_in, sh_ff, sh_in;
   cmp_type          r_step, s_step, sh_step;
   logic [7:0]       b;
   logic             body_bad;
   logic             lz_set;
   logic             sig_ok;

   assign b = step.sig_byte;

   dersig_cmp u_cmp_r (
      .use_half (1'b0),
      .st       (r_ff),
      .part_len (len_ff),
      .part_pos (pos_ff),
      .sig_byte (b),
      .st_next  (r_step)
   );

   dersig_cmp u_cmp_s (
      .use_half (1'b0),
      .st       (s_ff),
      .part_len (len_ff),
      .part_pos (pos_ff),
      .sig_byte (b),
      .st_next  (s_step)
   );

   dersig_cmp u_cmp_sh (
      .use_half (1'b1),
      .st       (sh_ff),
      .part_len (len_ff),
      .part_pos (pos_ff),
      .sig_byte (b),
      .st_next  (sh_step)
   );

   // negative value, lone zero, or redundant leading zero
   assign body_bad = ((pos_ff == '0) && (b[7] || (b == 8'h00 && len_ff == LEN_W'(1)))) ||
                     ((pos_ff == LEN_W'(1)) && lz_ff && !b[7]);
   assign lz_set   = (pos_ff == '0) && (b == 8'h00);

   always_comb begin
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      decl_in  = decl_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      lz_in    = lz_ff;
      inv_in   = inv_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      sh_in    = sh_ff;
      if (cnt_ff <= CNT_W'(MAX_SIG_BYTES)) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cnt_in > CNT_W'(MAX_SIG_BYTES)) begin
         inv_in = 1'b1;
      end
      if (!inv_in) begin
         case (phase_ff)
            PH_SEQ_TAG: begin
               if (b != TAG_SEQ) inv_in = 1'b1;
               phase_in = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
               decl_in  = b;
               phase_in = PH_R_TAG;
            end
            PH_R_TAG, PH_S_TAG: begin
               if (b != TAG_INT) inv_in = 1'b1;
               phase_in = (phase_ff == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
            end
            PH_R_LEN, PH_S_LEN: begin
               if (b == 8'h00 || b > 8'(MAX_PART_LEN)) inv_in = 1'b1;
               len_in   = b[LEN_W-1:0];
               pos_in   = '0;
               lz_in    = 1'b0;
               phase_in = (phase_ff == PH_R_LEN) ? PH_R_BODY : PH_S_BODY;
            end
            PH_R_BODY: begin
               if (body_bad) inv_in = 1'b1;
               if (lz_set) lz_in = 1'b1;
               r_in   = r_step;
               pos_in = pos_ff + LEN_W'(1);
               if (pos_in >= len_ff) phase_in = PH_S_TAG;
            end
            PH_S_BODY: begin
               if (pos_ff >= len_ff) begin
                  inv_in = 1'b1;
               end else begin
                  if (body_bad) inv_in = 1'b1;
                  if (lz_set) lz_in = 1'b1;
                  s_in   = s_step;
                  sh_in  = sh_step;
                  pos_in = pos_ff + LEN_W'(1);
               end
            end
            default: begin
               inv_in = 1'b1;
            end
         endcase
      end
   end

   assign sig_ok = !inv_in &&
                   (cnt_in >= CNT_W'(MIN_SIG_BYTES)) &&
                   ({1'b0, decl_in} + 9'd2 == 9'(cnt_in)) &&
                   (phase_in == PH_S_BODY) && (pos_in == len_in) &&
                   (r_in == CMP_LT) && (s_in == CMP_LT);

   always_comb begin
      status = STATUS_INVALID;
      if (sig_ok) begin
         status = (sh_in == CMP_GT) ? STATUS_CANONICAL : STATUS_LOW_S;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.en && step.last)) begin
         cnt_ff   <= '0;
         phase_ff <= PH_SEQ_TAG;
         decl_ff  <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
         lz_ff    <= 1'b0;
         inv_ff   <= 1'b0;
         r_ff     <= CMP_EQ;
         s_ff     <= CMP_EQ;
         sh_ff    <= CMP_EQ;
      end else if (step.en) begin
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         decl_ff  <= decl_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         lz_ff    <= lz_in;
         inv_ff   <= inv_in;
         r_ff     <= r_in;
         s_ff     <= s_in;
         sh_ff    <= sh_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SIG_BYTES + 1))
      else $error("byte count past saturation");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step.en && step.last |=> cnt_ff == '0 && phase_ff == PH_SEQ_TAG && !inv_ff)
      else $error("parse state not cleared after last word");

endmodule

### dv/tb_der_ecdsa_sig_canonical_check_core.sv
// Self-checking testbench for der_ecdsa_sig_canonical_check_core: drives DER
// signatures byte by byte, predicts each status word and compares it.
// Depends on dersig_pkg and the core RTL.
module tb_der_ecdsa_sig_canonical_check_core;
   import dersig_pkg::*;

   localparam logic [255:0] ORDER_N = {128'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFE,
                                       128'hBAAEDCE6AF48A03BBFD25E8CD0364141};
   localparam logic [255:0] HALF_N  = (ORDER_N - 256'd1) >> 1;
   localparam int RANDOM_WORDS    = 1030;
   localparam int MIN_RANDOM_SIGS = 20;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 3000;

   typedef enum logic [2:0] {
      AT_SEQ_TAG, AT_SEQ_LEN, AT_R_TAG, AT_R_LEN, AT_R_VAL, AT_S_TAG, AT_S_LEN, AT_S_VAL
   } parse_pos_type;

   class sig_status_board;
      logic [6:0] n_bytes;
      parse_pos_type pos;
      logic [7:0] body_len;
      logic [5:0] int_len;
      logic [5:0] int_pos;
      bit         zero_lead;
      bit         broken;
      cmp_type    r_cmp, s_cmp, s_half_cmp;
      logic [1:0] status_due[$];
      int         fail_count;

      function new();
         fail_count = 0;
         clear();
      endfunction

      function void clear();
         n_bytes = '0;
         pos = AT_SEQ_TAG;
         body_len = '0;
         int_len = '0;
         int_pos = '0;
         zero_lead = 1'b0;
         broken = 1'b0;
         r_cmp = CMP_EQ;
         s_cmp = CMP_EQ;
         s_half_cmp = CMP_EQ;
      endfunction

      // byte idx of n or (n-1)/2 right-aligned in 33 bytes
      static function logic [7:0] limit_byte(bit half, int idx);
         logic [263:0] w;
         w = {8'h00, half ? HALF_N : ORDER_N};
         return w[(32 - idx) * 8 +: 8];
      endfunction

      function cmp_type step_cmp(cmp_type st, bit half, logic [7:0] b);
         int idx;
         logic [7:0] lim_b;
         idx = MAX_PART_LEN - int'(int_len) + int'(int_pos);
         // shorter values skip nonzero limit bytes
         if (int_pos == 0) st = (int_len <= 31) ? CMP_LT : CMP_EQ;
         if (st != CMP_EQ || idx >= MAX_PART_LEN) return st;
         lim_b = limit_byte(half, idx);
         if (b < lim_b) return CMP_LT;
         if (b > lim_b) return CMP_GT;
         return CMP_EQ;
      endfunction

      function void value_rules(logic [7:0] b);
         if (int_pos == 0) begin
            if (b[7]) broken = 1'b1;
            if (b == 8'h00) begin
               zero_lead = 1'b1;
               if (int_len == 1) broken = 1'b1;
            end
         end else if (int_pos == 1 && zero_lead && !b[7]) begin
            broken = 1'b1;
         end
      endfunction

      function void parse(logic [7:0] b);
         case (pos)
            AT_SEQ_TAG: begin
               if (b != TAG_SEQ) broken = 1'b1;
               pos = AT_SEQ_LEN;
            end
            AT_SEQ_LEN: begin
               body_len = b;
               pos = AT_R_TAG;
            end
            AT_R_TAG, AT_S_TAG: begin
               if (b != TAG_INT) broken = 1'b1;
               pos = (pos == AT_R_TAG) ? AT_R_LEN : AT_S_LEN;
            end
            AT_R_LEN, AT_S_LEN: begin
               if (b < 1 || b > MAX_PART_LEN) broken = 1'b1;
               int_len = b[5:0];
               int_pos = '0;
               zero_lead = 1'b0;
               pos = (pos == AT_R_LEN) ? AT_R_VAL : AT_S_VAL;
            end
            AT_R_VAL: begin
               value_rules(b);
               r_cmp = step_cmp(r_cmp, 1'b0, b);
               int_pos = int_pos + 6'd1;
               if (int_pos >= int_len) pos = AT_S_TAG;
            end
            default: begin
               if (int_pos >= int_len) begin
                  broken = 1'b1;
               end else begin
                  value_rules(b);
                  s_cmp = step_cmp(s_cmp, 1'b0, b);
                  s_half_cmp = step_cmp(s_half_cmp, 1'b1, b);
                  int_pos = int_pos + 6'd1;
               end
            end
         endcase
      endfunction

      function void take_byte(logic [7:0] b, bit last);
         logic [1:0] status;
         if (n_bytes <= MAX_SIG_BYTES) n_bytes = n_bytes + 7'd1;
         if (n_bytes > MAX_SIG_BYTES) broken = 1'b1;
         if (!broken) parse(b);
         if (!last) return;
         status = STATUS_INVALID;
         if (!broken && n_bytes >= MIN_SIG_BYTES && int'(n_bytes) == int'(body_len) + 2 &&
             pos == AT_S_VAL && int_pos == int_len && r_cmp == CMP_LT && s_cmp == CMP_LT)
            status = (s_half_cmp == CMP_GT) ? STATUS_CANONICAL : STATUS_LOW_S;
         status_due.push_back(status);
         clear();
      endfunction

      function void check_status(logic [7:0] word);
         logic [1:0] want;
         if (status_due.size() == 0) begin
            $error("status: expected none, got %0d", word[1:0]);
            fail_count++;
            return;
         end
         want = status_due.pop_front();
         if (word[1:0] != want) begin
            $error("status: expected %0d, got %0d", want, word[1:0]);
            fail_count++;
         end
         if (word[7:2] != 6'd0) begin
            $error("pad: expected 0, got %0h", word[7:2]);
            fail_count++;
         end
      endfunction

      function int pending();
         return status_due.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;

   sig_status_board sb;
   logic [7:0] r_val[$];
   logic [7:0] s_val[$];
   logic [7:0] sig_q[$];
   int         words_sent;
   int         sigs_sent;
   int         burst_left;
   int         stall_cycles = 0;
   bit         hold_req;
   bit         hold_done;

   der_ecdsa_sig_canonical_check_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sig_byte(logic [7:0] b, bit last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata <= 8'($urandom);
            req_tlast <= 1'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.take_byte(b, last);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_signature();
      foreach (sig_q[i]) send_sig_byte(sig_q[i], i == sig_q.size() - 1);
      sigs_sent++;
   endtask

   task automatic make_canonical(ref logic [7:0] v[$]);
      while (v.size() > 1 && v[0] == 8'h00) void'(v.pop_front());
      if (v[0][7]) v.push_front(8'h00);
   endtask

   task automatic fill_limit(bit half, ref logic [7:0] v[$]);
      v.delete();
      for (int i = 1; i <= 32; i++) v.push_back(sig_status_board::limit_byte(half, i));
   endtask

   // n or (n-1)/2 with the low byte nudged by adj
   task automatic limit_value(bit half, int adj, ref logic [7:0] v[$]);
      fill_limit(half, v);
      v[31] = v[31] + 8'(adj);
      make_canonical(v);
   endtask

   task automatic random_value(ref logic [7:0] v[$]);
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      v.delete();
      if (kind < 4) begin
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 32);
         repeat (len) v.push_back(8'($urandom));
      end else if (kind < 9) begin
         fill_limit(kind >= 7, v);
         case ($urandom_range(0, 3))
            0: ;
            1: v[31] = v[31] - 8'd1;
            2: v[31] = v[31] + 8'd1;
            default: v[$urandom_range(0, 31)] = 8'($urandom);
         endcase
      end else begin
         v.push_back(8'($urandom_range(0, 2)));
      end
      make_canonical(v);
   endtask

   task automatic build_sig();
      sig_q.delete();
      sig_q.push_back(TAG_SEQ);
      sig_q.push_back(8'(4 + r_val.size() + s_val.size()));
      sig_q.push_back(TAG_INT);
      sig_q.push_back(8'(r_val.size()));
      foreach (r_val[i]) sig_q.push_back(r_val[i]);
      sig_q.push_back(TAG_INT);
      sig_q.push_back(8'(s_val.size()));
      foreach (s_val[i]) sig_q.push_back(s_val[i]);
   endtask

   task automatic damage_sig();
      int n;
      case ($urandom_range(0, 6))
         0: sig_q[$urandom_range(0, sig_q.size() - 1)] = 8'($urandom);
         1: begin
            n = $urandom_range(0, sig_q.size() - 1);
            sig_q[n] = sig_q[n] ^ 8'(1 << $urandom_range(0, 7));
         end
         2: begin
            n = $urandom_range(1, sig_q.size() - 1);
            repeat (n) void'(sig_q.pop_back());
         end
         3: begin
            n = $urandom_range(1, 6);
            repeat (n) sig_q.push_back(8'($urandom));
            if ($urandom_range(0, 1)) sig_q[1] = sig_q[1] + 8'(n);
         end
         4: begin
            sig_q.insert(4, 8'h00);
            sig_q[3] = sig_q[3] + 8'd1;
            sig_q[1] = sig_q[1] + 8'd1;
         end
         5: sig_q[1] = sig_q[1] + 8'($urandom_range(1, 255));
         default: begin
            n = $urandom_range(73, 80);
            while (sig_q.size() < n) sig_q.push_back(8'($urandom));
         end
      endcase
   endtask

   task automatic make_noise();
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(73, 100) : $urandom_range(1, 20);
      sig_q.delete();
      repeat (len) sig_q.push_back(8'($urandom));
      if ($urandom_range(0, 1)) sig_q[0] = TAG_SEQ;
   endtask

   task automatic directed_sigs();
      r_val = {8'h01}; s_val = {8'h01}; build_sig(); send_signature();
      limit_value(1'b0, -1, r_val); limit_value(1'b1, 0, s_val); build_sig(); send_signature();
      r_val = {8'h7F}; limit_value(1'b1, 1, s_val); build_sig(); send_signature();
      limit_value(1'b0, 0, r_val); s_val = {8'h01}; build_sig(); send_signature();
      r_val = {8'h01}; limit_value(1'b0, -1, s_val); build_sig(); send_signature();
      limit_value(1'b0, 0, s_val); build_sig(); send_signature();
      r_val = {8'h00, 8'hFF}; s_val = {8'h00, 8'h80}; build_sig(); send_signature();
      // zero, negative and redundant leading zero
      r_val = {8'h00}; s_val = {8'h01}; build_sig(); send_signature();
      r_val = {8'h80}; build_sig(); send_signature();
      r_val = {8'h00, 8'h01}; build_sig(); send_signature();
      // trailing byte with a consistent sequence length
      r_val = {8'h01}; build_sig(); sig_q.push_back(8'h00); sig_q[1] = sig_q[1] + 8'd1;
      send_signature();
      // stream ends inside S
      limit_value(1'b0, -1, r_val); limit_value(1'b1, 0, s_val); build_sig();
      repeat (3) void'(sig_q.pop_back());
      send_signature();
      r_val = {8'h01}; s_val = {8'h01}; build_sig(); sig_q[1] = sig_q[1] + 8'd1; send_signature();
      build_sig(); sig_q[0] = 8'h31; send_signature();
      build_sig(); sig_q[5] = 8'h03; send_signature();
      build_sig(); sig_q[3] = 8'd0; send_signature();
      build_sig(); sig_q[6] = 8'd34; send_signature();
      // longest legal signature, then one byte too many
      limit_value(1'b0, -1, r_val); limit_value(1'b0, -1, s_val); build_sig(); send_signature();
      sig_q.push_back(8'h00); send_signature();
      sig_q.delete();
      repeat (80) sig_q.push_back(8'hFF);
      send_signature();
      sig_q = {TAG_SEQ}; send_signature();
   endtask

   // result side: stall patterns plus one long hold-off
   initial begin : rsp_side
      int mode;
      int mode_left;
      bit rdy;
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) != 0);
            default: rdy = ($urandom_range(0, 7) == 0);
         endcase
         rsp_tready <= rdy;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_status(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      int pick;
      int random_start;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tlast = 1'b0;
      words_sent = 0;
      sigs_sent = 0;
      burst_left = 0;
      hold_req = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_sigs();

      random_start = words_sent;
      sigs_sent = 0;
      while (words_sent - random_start < RANDOM_WORDS || sigs_sent < MIN_RANDOM_SIGS) begin
         if (words_sent - random_start > RANDOM_WORDS / 2) hold_req = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            make_noise();
         end else begin
            random_value(r_val);
            random_value(s_val);
            build_sig();
            if (pick < 32) damage_sig();
         end
         send_signature();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
